@@ hw/rtl/dpam_pkg.sv @@
// Shared constants and types for the duplicate point angle merge block.
package dpam_pkg;

    localparam int MAX_GROUP = 64;
    localparam int ADDR_W    = $clog2(MAX_GROUP);
    localparam int FILL_W    = $clog2(MAX_GROUP + 1);
    localparam int ANGLE_W   = 32;
    localparam int TOT_W     = 40;
    localparam int HW_W      = 24;
    localparam logic [HW_W-1:0] HW_RESET = 24'd23040;

    localparam int DATA_W  = 200;
    localparam int X_LO    = 0;
    localparam int Y_LO    = 32;
    localparam int Z_LO    = 64;
    localparam int POS_W   = 96;
    localparam int ANG_LO  = 96;
    localparam int NX_LO   = 128;
    localparam int NY_LO   = 144;
    localparam int NZ_LO   = 160;
    localparam int RED_LO  = 176;
    localparam int GRN_LO  = 184;
    localparam int BLU_LO  = 192;

    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // One classified point on its way from the front to the back.
    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              close_prev;
        logic              new_group;
        logic              eoc;
    } dpam_item_t;

endpackage

@@ hw/rtl/dpam_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
module dpam_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ hw/rtl/dpam_front.sv @@
// Front end: accepts points and marks group boundaries against the open group.
module dpam_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [dpam_pkg::DATA_W-1:0] in_data,
    input  logic                        in_last,
    output logic                        push,
    output dpam_pkg::dpam_item_t        push_item,
    input  logic                        q_full
);
    import dpam_pkg::*;

    logic             open_reg;
    logic             open_next;
    logic [POS_W-1:0] head_pos_reg;
    logic [POS_W-1:0] head_pos_next;
    logic             same;

    assign in_ready = !q_full;
    assign push     = in_valid && in_ready;
    assign same     = open_reg && (in_data[POS_W-1:0] == head_pos_reg);

    always_comb
    begin
        push_item.data       = in_data;
        push_item.close_prev = open_reg && !same;
        push_item.new_group  = !same;
        push_item.eoc        = in_last;
        open_next            = open_reg;
        head_pos_next        = head_pos_reg;
        if (push)
        begin
            open_next = !in_last;
            if (!same)
            begin
                head_pos_next = in_data[POS_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg     <= 1'b0;
            head_pos_reg <= '0;
        end
        else
        begin
            open_reg     <= open_next;
            head_pos_reg <= head_pos_next;
        end
    end

endmodule

@@ hw/rtl/dpam_queue.sv @@
// Two-entry queue between the front end and the back end.
module dpam_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  dpam_pkg::dpam_item_t push_item,
    output logic                 full,
    input  logic                 pop,
    output logic                 not_empty,
    output dpam_pkg::dpam_item_t pop_item
);
    import dpam_pkg::*;

    dpam_item_t        slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full      = (count_reg == QCNT_W'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

@@ hw/rtl/dpam_div.sv @@
// Bit-serial signed divider: window total over window length, truncated to zero.
module dpam_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic signed [dpam_pkg::TOT_W-1:0] dividend,
    input  logic [dpam_pkg::FILL_W-1:0]  divisor,
    output logic                         done,
    output logic [dpam_pkg::ANGLE_W-1:0] quotient
);
    import dpam_pkg::*;

    localparam int CNT_W = $clog2(TOT_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic              neg_reg;
    logic              zero_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [TOT_W-1:0]  q_reg;
    logic [FILL_W-1:0] r_reg;
    logic [FILL_W-1:0] d_reg;
    logic [FILL_W:0]   shifted;
    logic              ge;
    logic [FILL_W:0]   diff;
    logic [ANGLE_W-1:0] q_low;

    assign shifted = {r_reg, q_reg[TOT_W-1]};
    assign ge      = shifted >= {1'b0, d_reg};
    assign diff    = shifted - {1'b0, d_reg};
    assign q_low   = q_reg[ANGLE_W-1:0];
    assign done    = done_reg;
    assign quotient = zero_reg ? '0 : (neg_reg ? (~q_low + 1'b1) : q_low);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(TOT_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg  <= dividend[TOT_W-1];
            zero_reg <= (divisor == '0);
            q_reg    <= dividend[TOT_W-1] ? (~dividend + 1'b1) : dividend;
            r_reg    <= '0;
            d_reg    <= divisor;
        end
        else if (busy_reg)
        begin
            r_reg <= ge ? diff[FILL_W-1:0] : shifted[FILL_W-1:0];
            q_reg <= {q_reg[TOT_W-2:0], ge};
        end
    end

endmodule

@@ hw/rtl/dpam_back.sv @@
// Back end: group state, angle window shrink, merge result and output register.
module dpam_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [dpam_pkg::HW_W-1:0]   cfg_wr_data,
    input  logic                        q_not_empty,
    input  dpam_pkg::dpam_item_t        q_item,
    output logic                        q_pop,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [dpam_pkg::DATA_W-1:0] out_data,
    output logic                        out_overflow,
    output logic                        out_last
);
    import dpam_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_DIVW = 4'd1;
    localparam logic [3:0] ST_EMIT = 4'd2;
    localparam logic [3:0] ST_ADD  = 4'd3;
    localparam logic [3:0] ST_CHK  = 4'd4;
    localparam logic [3:0] ST_MUL  = 4'd5;
    localparam logic [3:0] ST_CMP  = 4'd6;
    localparam logic [3:0] ST_BEST = 4'd7;
    localparam logic [3:0] ST_FIN  = 4'd8;

    localparam int PV_W = ANGLE_W + FILL_W + 1;
    localparam int D_W  = TOT_W + 2;

    logic [3:0]             state_reg;
    dpam_item_t             item_reg;
    logic                   eoc_emit_reg;
    logic [HW_W-1:0]        hw_reg;
    logic [DATA_W-1:0]      head_reg;
    logic [FILL_W-1:0]      fill_reg;
    logic [ADDR_W-1:0]      start_reg;
    logic signed [TOT_W-1:0] total_reg;
    logic [FILL_W-1:0]      best_len_reg;
    logic signed [TOT_W-1:0] best_total_reg;
    logic                   ovf_reg;
    logic signed [ANGLE_W-1:0] v_reg;
    logic signed [PV_W-1:0] prod_v_reg;
    logic signed [D_W-1:0]  prod_h_reg;
    logic                   out_valid_reg;
    logic [DATA_W-1:0]      out_data_reg;
    logic                   out_ovf_reg;
    logic                   out_last_reg;

    logic [FILL_W-1:0]      f0;
    logic signed [ANGLE_W-1:0] angle;
    logic [FILL_W-1:0]      count;
    logic [FILL_W-1:0]      start_ext;
    logic signed [D_W-1:0]  d;
    logic                   in_range;
    logic                   ram_we;
    logic                   ram_re;
    logic [ANGLE_W-1:0]     ram_q;
    logic                   div_start;
    logic                   div_done;
    logic [ANGLE_W-1:0]     mean;
    logic                   out_free;

    assign angle     = item_reg.data[ANG_LO +: ANGLE_W];
    assign f0        = item_reg.new_group ? '0 : fill_reg;
    assign start_ext = {1'b0, start_reg};
    assign count     = fill_reg - start_ext;
    assign d         = D_W'(prod_v_reg) - D_W'(total_reg);
    assign in_range  = (d >= -prod_h_reg) && (d <= prod_h_reg);
    assign ram_we    = (state_reg == ST_ADD) && (f0 != FILL_W'(MAX_GROUP));
    assign ram_re    = (state_reg == ST_CHK);
    assign q_pop     = (state_reg == ST_IDLE) && q_not_empty;
    assign div_start = (q_pop && q_item.close_prev) || ((state_reg == ST_FIN) && item_reg.eoc);
    assign out_free  = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign out_data     = out_data_reg;
    assign out_overflow = out_ovf_reg;
    assign out_last     = out_last_reg;

    dpam_ram #(.WIDTH(ANGLE_W), .DEPTH(MAX_GROUP)) u_angle_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (f0[ADDR_W-1:0]),
        .wr_data (angle),
        .rd_en   (ram_re),
        .rd_addr (start_reg),
        .rd_data (ram_q)
    );

    dpam_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (best_total_reg),
        .divisor  (best_len_reg),
        .done     (div_done),
        .quotient (mean)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            hw_reg         <= HW_RESET;
            out_valid_reg  <= 1'b0;
            eoc_emit_reg   <= 1'b0;
            head_reg       <= '0;
            fill_reg       <= '0;
            start_reg      <= '0;
            total_reg      <= '0;
            best_len_reg   <= '0;
            best_total_reg <= '0;
            ovf_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                hw_reg <= cfg_wr_data;
            end
            if ((state_reg == ST_EMIT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (q_pop)
                    begin
                        eoc_emit_reg <= 1'b0;
                        state_reg    <= q_item.close_prev ? ST_DIVW : ST_ADD;
                    end
                end
                ST_DIVW:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        state_reg <= eoc_emit_reg ? ST_IDLE : ST_ADD;
                    end
                end
                ST_ADD:
                begin
                    if (item_reg.new_group)
                    begin
                        head_reg       <= item_reg.data;
                        start_reg      <= '0;
                        best_len_reg   <= '0;
                        best_total_reg <= '0;
                    end
                    if (ram_we)
                    begin
                        fill_reg  <= f0 + 1'b1;
                        total_reg <= (item_reg.new_group ? '0 : total_reg) + TOT_W'(angle);
                        ovf_reg   <= item_reg.new_group ? 1'b0 : ovf_reg;
                        state_reg <= ST_CHK;
                    end
                    else
                    begin
                        ovf_reg   <= 1'b1;
                        state_reg <= ST_BEST;
                    end
                end
                ST_CHK:
                begin
                    state_reg <= (start_ext + 1'b1 < fill_reg) ? ST_MUL : ST_BEST;
                end
                ST_MUL:
                begin
                    state_reg <= ST_CMP;
                end
                ST_CMP:
                begin
                    if (in_range)
                    begin
                        state_reg <= ST_BEST;
                    end
                    else
                    begin
                        total_reg <= total_reg - TOT_W'(v_reg);
                        start_reg <= start_reg + 1'b1;
                        state_reg <= ST_CHK;
                    end
                end
                ST_BEST:
                begin
                    if (count > best_len_reg)
                    begin
                        best_len_reg   <= count;
                        best_total_reg <= total_reg;
                    end
                    state_reg <= ST_FIN;
                end
                ST_FIN:
                begin
                    if (item_reg.eoc)
                    begin
                        eoc_emit_reg <= 1'b1;
                        state_reg    <= ST_DIVW;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            item_reg <= q_item;
        end
        if (state_reg == ST_MUL)
        begin
            v_reg      <= ram_q;
            prod_v_reg <= PV_W'(signed'(ram_q)) * PV_W'(signed'({1'b0, count}));
            prod_h_reg <= D_W'({1'b0, hw_reg}) * D_W'({1'b0, count});
        end
        if ((state_reg == ST_EMIT) && out_free)
        begin
            out_data_reg <= {head_reg[DATA_W-1:ANG_LO + ANGLE_W], mean, head_reg[POS_W-1:0]};
            out_ovf_reg  <= ovf_reg;
            out_last_reg <= eoc_emit_reg || !item_reg.eoc;
        end
    end

    // The group never holds more angles than the store has entries.
    assert property (@(posedge clk) disable iff (!rst_n) fill_reg <= FILL_W'(MAX_GROUP))
        else $error("fill count beyond group capacity");

    // The best window is never longer than the angles taken so far.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_ADD) |-> (best_len_reg <= fill_reg))
        else $error("best window longer than group");

    // A stored angle enters the window arithmetic only while the window keeps at least two entries.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |-> (start_ext + 1'b1 < fill_reg))
        else $error("window shrink past newest angle");

    // A division starts only from an idle or finishing sequencer.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (state_reg == ST_IDLE || state_reg == ST_FIN))
        else $error("divider started mid-item");

endmodule

@@ hw/rtl/duplicate_point_angle_merge.sv @@
// Top level of the duplicate point angle merge block.
//
//  Channel  Direction  Handshake             Content
//  s_axis   in         tvalid/tready         one point, tlast = end of cloud
//  m_axis   out        tvalid/tready         one merged point per closed group
//  cfg      in         cfg_wr_en             window half width, Q.8 degrees
//
// The back-end sequencer and its one angle RAM read port set the pace. An
// item that stays in its group passes add, check, multiply, compare, best and
// finish before the next queue read, plus multiply, compare and check for each
// stored angle the window drops; the first point of a group skips multiply and
// compare. Closing a group first waits on the bit-serial divider that forms the
// window mean, then loads the output register, longer while the sink stalls.
// Reset clears the group state and loads the default half width of 90
// degrees; the angle RAM needs no clearing since only written entries are read.
// The front end takes points while the two-entry queue has room, and the
// output register lets the back end finish a transfer while the sink stalls.
module duplicate_point_angle_merge (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [23:0]  cfg_wr_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // x_in, y_in, z_in, angle_in, normal_x_in, normal_y_in, normal_z_in,
    // red_in, green_in, blue_in
    input  logic [199:0] s_axis_tdata,
    // end_of_cloud
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // x_out, y_out, z_out, angle_out, normal_x_out, normal_y_out,
    // normal_z_out, red_out, green_out, blue_out
    output logic [199:0] m_axis_tdata,
    // group_overflow
    output logic         m_axis_tuser,
    // last_result
    output logic         m_axis_tlast
);
    import dpam_pkg::*;

    logic       push;
    dpam_item_t push_item;
    logic       q_full;
    logic       q_pop;
    logic       q_not_empty;
    dpam_item_t q_item;

    // The front end decides, per point, whether the open group closes first.
    dpam_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .push      (push),
        .push_item (push_item),
        .q_full    (q_full)
    );

    // The queue decouples acceptance from the window arithmetic.
    dpam_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_item  (q_item)
    );

    // The back end runs the window and drives the output transfer.
    dpam_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .q_not_empty  (q_not_empty),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_data     (m_axis_tdata),
        .out_overflow (m_axis_tuser),
        .out_last     (m_axis_tlast)
    );

endmodule

@@ bench/dpam_checker.sv @@
// Checker for the duplicate point angle merge block: predicts merged points and compares them.
module dpam_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [23:0]  cfg_wr_data,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [199:0] s_axis_tdata,
    input  logic         s_axis_tlast,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [199:0] m_axis_tdata,
    input  logic         m_axis_tuser,
    input  logic         m_axis_tlast,
    output int           fail_count,
    output int           pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import dpam_pkg::*;

    typedef struct {
        logic [DATA_W-1:0] data;
        logic              overflow;
        logic              last;
    } merged_point_t;

    merged_point_t merged_q[$];

    // Predicted group state.
    logic [HW_W-1:0]   half_width;
    longint            angles[MAX_GROUP];
    logic [DATA_W-1:0] head;
    logic              open_grp;
    int                fill;
    int                win_start;
    longint            win_total;
    int                best_len;
    longint            best_total;
    logic              ovf_seen;

    string field_name[10] = '{"x_out", "y_out", "z_out", "angle_out", "normal_x_out",
                              "normal_y_out", "normal_z_out", "red_out", "green_out",
                              "blue_out"};
    int field_lo[10] = '{X_LO, Y_LO, Z_LO, ANG_LO, NX_LO, NY_LO, NZ_LO, RED_LO, GRN_LO, BLU_LO};
    int field_w[10]  = '{32, 32, 32, 32, 16, 16, 16, 8, 8, 8};

    task automatic close_group();
        merged_point_t r;
        longint        mean;
        mean = (best_len != 0) ? best_total / best_len : 0;
        r.data = head;
        r.data[ANG_LO +: 32] = mean[31:0];
        r.overflow = ovf_seen;
        r.last = 1'b0;
        merged_q.insert(merged_q.size(), r);
        open_grp = 1'b0;
    endtask

    task automatic add_angle(longint a);
        longint cnt;
        longint v;
        longint d;
        longint lim;
        if (fill >= MAX_GROUP)
        begin
            ovf_seen = 1'b1;
            return;
        end
        angles[fill] = a;
        fill++;
        win_total += a;
        cnt = fill - win_start;
        // Drop the oldest angles until the oldest one sits within the half
        // width of the window mean; the newest angle always stays.
        while (win_start + 1 < fill)
        begin
            v = angles[win_start];
            d = v * cnt - win_total;
            lim = longint'(half_width) * cnt;
            if (d >= -lim && d <= lim)
                break;
            win_total -= v;
            win_start++;
            cnt--;
        end
        if (fill - win_start > best_len)
        begin
            best_len = fill - win_start;
            best_total = win_total;
        end
    endtask

    task automatic merge_point(logic [DATA_W-1:0] d, logic eoc);
        int n0;
        n0 = merged_q.size();
        if (open_grp && d[POS_W-1:0] != head[POS_W-1:0])
            close_group();
        if (!open_grp)
        begin
            head = d;
            fill = 0;
            win_start = 0;
            win_total = 0;
            best_len = 0;
            best_total = 0;
            ovf_seen = 1'b0;
            open_grp = 1'b1;
        end
        add_angle(longint'(signed'(d[ANG_LO +: 32])));
        if (eoc)
            close_group();
        if (merged_q.size() > n0)
            merged_q[$].last = 1'b1;
    endtask

    task automatic check_result();
        merged_point_t e;
        logic [31:0] ev;
        logic [31:0] av;
        logic [31:0] mask;
        if (merged_q.size() == 0)
        begin
            $error("unexpected result transfer, data %h", m_axis_tdata);
            fail_count++;
            return;
        end
        e = merged_q.pop_front();
        for (int i = 0; i < 10; i++)
        begin
            mask = 32'((64'd1 << field_w[i]) - 64'd1);
            ev = 32'(e.data >> field_lo[i]) & mask;
            av = 32'(m_axis_tdata >> field_lo[i]) & mask;
            if (ev !== av)
            begin
                $error("%s: expected %h, got %h", field_name[i], ev, av);
                fail_count++;
            end
        end
        if (e.overflow !== m_axis_tuser)
        begin
            $error("group_overflow: expected %b, got %b", e.overflow, m_axis_tuser);
            fail_count++;
        end
        if (e.last !== m_axis_tlast)
        begin
            $error("last_result: expected %b, got %b", e.last, m_axis_tlast);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_width = HW_RESET;
            head = '0;
            open_grp = 1'b0;
            fill = 0;
            win_start = 0;
            win_total = 0;
            best_len = 0;
            best_total = 0;
            ovf_seen = 1'b0;
            merged_q.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_result();
            if (cfg_wr_en)
                half_width = cfg_wr_data;
            if (s_axis_tvalid && s_axis_tready)
                merge_point(s_axis_tdata, s_axis_tlast);
            pending = merged_q.size();
        end
    end
endmodule

@@ bench/duplicate_point_angle_merge_test.sv @@
// Testbench top for the duplicate point angle merge block: stimulus, phases and verdict.
module duplicate_point_angle_merge_test;
    import dpam_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic         clk;
    logic         rst_n;
    logic         cfg_wr_en;
    logic [23:0]  cfg_wr_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [199:0] s_axis_tdata;
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [199:0] m_axis_tdata;
    logic         m_axis_tuser;
    logic         m_axis_tlast;
    int           fail_count;
    int           pending;

    // Percent chance per cycle that the source holds back or the sink stalls.
    int src_idle_pct;
    int sink_stall_pct;

    // Cycles to let pass after the last result: a point that opens no result
    // may still be walking the window, longer the more angles it drops.
    localparam int DRAIN_CYCLES = 400;

    duplicate_point_angle_merge u_top (.*);

    dpam_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Generous overall limit; the slowest legal run stays far below it.
    initial
    begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

    // The sink decides afresh every cycle whether it takes a transfer.
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);

    function automatic logic [199:0] pack_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                                logic [31:0] ang, logic [15:0] nx,
                                                logic [15:0] ny, logic [15:0] nz,
                                                logic [7:0] r, logic [7:0] g, logic [7:0] b);
        return {b, g, r, nz, ny, nx, ang, z, y, x};
    endfunction

    function automatic logic [15:0] rand_normal();
        case ($urandom_range(7))
            0: return 16'sd16384;
            1: return -16'sd16384;
            default: return 16'($urandom_range(32768) - 16384);
        endcase
    endfunction

    // Offers one point and returns at the edge where it is accepted. The
    // valid stays high into the next call, so only one assignment per step.
    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                              logic [31:0] ang, logic eoc);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pack_point(x, y, z, ang, rand_normal(), rand_normal(), rand_normal(),
                                    8'($urandom), 8'($urandom), 8'($urandom));
        s_axis_tlast  <= eoc;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Register writes happen only while nothing is in flight.
    task automatic write_half_width(logic [23:0] v);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // One group of points that share a position, angles mostly rising in steps
    // drawn around the half width so that windows both hold and slide.
    task automatic send_group(logic [23:0] hw, int len, logic eoc_at_end);
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] ang;
        x = $urandom;
        y = $urandom;
        z = $urandom;
        case ($urandom_range(3))
            0: ang = 32'h8000_0000 + $urandom_range(255);
            1: ang = 32'h7FFF_FFFF - $urandom_range(65535);
            default: ang = $urandom;
        endcase
        for (int i = 0; i < len; i++)
        begin
            send_point(x, y, z, ang, eoc_at_end && (i == len - 1));
            case ($urandom_range(9))
                0: ang = ang + $urandom;
                1: ang = ang;
                default: ang = ang + $urandom_range(32'(hw) * 2 + 1);
            endcase
        end
    endtask

    task automatic random_phase(logic [23:0] hw, int items);
        int sent;
        int len;
        sent = 0;
        while (sent < items)
        begin
            case ($urandom_range(19))
                0: len = $urandom_range(63, 70);
                1, 2: len = 1;
                default: len = $urandom_range(2, 8);
            endcase
            // Occasionally end the cloud inside the run of points.
            send_group(hw, len, $urandom_range(9) == 0);
            sent += len;
        end
        // Close whatever is open so the phase drains completely.
        send_point($urandom, $urandom, $urandom, $urandom, 1'b1);
    endtask

    logic [23:0] phase_hw[5];

    initial
    begin
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        src_idle_pct  = 0;
        sink_stall_pct = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset half width: extreme positions and angles,
        // a position change closing a group, an end of cloud on a single point,
        // a newest angle far outside the window, and a revisited position.
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd23040, 1'b0);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd46081, 1'b0);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd46081, 1'b1);
        send_point(32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 1'b1);
        send_point(32'h0, 32'h0, 32'h0, 32'hFFFF_FF00, 1'b0);
        send_point(32'h0, 32'h0, 32'h1, 32'hFFFF_FFFF, 1'b0);
        send_point(32'h0, 32'h0, 32'h0, 32'h0000_0100, 1'b0);
        send_point(32'h0, 32'h0, 32'h0, 32'hFFFF_FE00, 1'b0);
        send_point(32'h0, 32'h0, 32'h0, 32'hFFFF_FD00, 1'b1);
        write_half_width(24'd0);
        send_point(32'h5, 32'h5, 32'h5, 32'd100, 1'b0);
        send_point(32'h5, 32'h5, 32'h5, 32'd100, 1'b0);
        send_point(32'h5, 32'h5, 32'h5, 32'd101, 1'b0);
        send_point(32'h5, 32'h5, 32'h5, 32'd101, 1'b1);
        write_half_width(24'hFF_FFFF);
        send_point(32'h6, 32'h6, 32'h6, 32'h8000_0000, 1'b0);
        send_point(32'h6, 32'h6, 32'h6, 32'h7FFF_FFFF, 1'b1);

        // Random phases, each at its own half width; the idling pattern repeats every four phases.
        phase_hw = '{24'd23040, 24'd0, 24'hFF_FFFF, 24'($urandom_range(1, 4096)),
                     24'($urandom)};
        for (int p = 0; p < 5; p++)
        begin
            write_half_width(phase_hw[p]);
            case (p % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 88; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 88; end
                default: begin src_idle_pct = 29; sink_stall_pct = 29; end
            endcase
            random_phase(phase_hw[p], 120);
        end

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
